### rtl/core/lrgd_pkg.sv
`timescale 1ns / 1ps

package lrgd_pkg;

  localparam int DEF_MAX_SAMPLES  = 256;
  localparam int DEF_MAX_FEATURES = 16;
  localparam int FEAT_LIMIT       = 16;

  localparam logic [1:0] CMD_FEATURE = 2'd0;
  localparam logic [1:0] CMD_TARGET  = 2'd1;
  localparam logic [1:0] CMD_START   = 2'd2;
  localparam logic [1:0] CMD_CLEAR   = 2'd3;

  localparam logic [1:0] REG_FEATURE_COUNT  = 2'd0;
  localparam logic [1:0] REG_LEARN_RATE     = 2'd1;
  localparam logic [1:0] REG_STOP_THRESHOLD = 2'd2;
  localparam logic [1:0] REG_ITERATION_CAP  = 2'd3;

  localparam logic [4:0]  RST_FEATURE_COUNT  = 5'd1;
  localparam logic [23:0] RST_LEARN_RATE     = 24'd65536;
  localparam logic [31:0] RST_STOP_THRESHOLD = 32'd65;
  localparam logic [15:0] RST_ITERATION_CAP  = 16'd1000;

  localparam logic [63:0] PRIOR_COST = 64'd10000001 << 16;
  localparam logic [63:0] INT64_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] STEP_LIM   = 64'h0000_0100_0000_0000;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] value;
  } lrgd_in_t;

  typedef struct packed {
    logic signed [31:0] weight;
    logic [3:0]         weight_index;
    logic               last;
    logic               status;
    logic [15:0]        passes;
  } lrgd_out_t;

  typedef struct packed {
    logic start;
    logic shift24;
    logic lim_step;
  } lrgd_mul_req_t;

endpackage

### rtl/core/lrgd_mul.sv
`timescale 1ns / 1ps

module lrgd_mul (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lrgd_pkg::lrgd_mul_req_t req,
  input  logic signed [63:0]    op_a,
  input  logic signed [63:0]    op_b,
  output logic                  done,
  output logic signed [63:0]    result
);

  localparam logic [2:0] PH_LAST_PP = 3'd3;
  localparam logic [2:0] PH_ROUND   = 3'd4;
  localparam logic [2:0] PH_CLAMP   = 3'd5;

  logic                busy_r, busy_nxt;
  logic [2:0]          ph_r, ph_nxt;
  logic [63:0]         ua_r, ua_nxt, ub_r, ub_nxt;
  logic                neg_r, neg_nxt, sh24_r, sh24_nxt, lstep_r, lstep_nxt;
  logic [127:0]        acc_r, acc_nxt;
  logic [112:0]        q_r, q_nxt;
  logic signed [63:0]  res_r, res_nxt;
  logic                done_r, done_nxt;

  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [112:0] q_shift;
  logic         rem_nz;
  logic [63:0]  lim, mag;

  always_comb begin
    pa = ph_r[0] ? ua_r[63:32] : ua_r[31:0];
    pb = ph_r[1] ? ub_r[63:32] : ub_r[31:0];
    pp = pa * pb;
    unique case ({ph_r[1], ph_r[0]})
      2'b00:   pp_sh = {64'd0, pp};
      2'b11:   pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
    q_shift = sh24_r ? 113'(acc_r >> 24) : 113'(acc_r >> 16);
    rem_nz  = sh24_r ? (acc_r[23:0] != 24'd0) : (acc_r[15:0] != 16'd0);
    lim     = lstep_r ? lrgd_pkg::STEP_LIM : lrgd_pkg::INT64_MAX;
    mag     = ((q_r[112:64] != 49'd0) || (q_r[63:0] > lim)) ? lim : q_r[63:0];
  end

  always_comb begin
    busy_nxt  = busy_r;
    ph_nxt    = ph_r;
    ua_nxt    = ua_r;
    ub_nxt    = ub_r;
    neg_nxt   = neg_r;
    sh24_nxt  = sh24_r;
    lstep_nxt = lstep_r;
    acc_nxt   = acc_r;
    q_nxt     = q_r;
    res_nxt   = res_r;
    done_nxt  = 1'b0;
    if (req.start) begin
      busy_nxt  = 1'b1;
      ph_nxt    = 3'd0;
      ua_nxt    = op_a[63] ? 64'(-op_a) : 64'(op_a);
      ub_nxt    = op_b[63] ? 64'(-op_b) : 64'(op_b);
      neg_nxt   = op_a[63] ^ op_b[63];
      sh24_nxt  = req.shift24;
      lstep_nxt = req.lim_step;
      acc_nxt   = 128'd0;
    end else if (busy_r) begin
      ph_nxt = ph_r + 3'd1;
      if (ph_r <= PH_LAST_PP) begin
        acc_nxt = acc_r + pp_sh;
      end else if (ph_r == PH_ROUND) begin
        q_nxt = q_shift + 113'(neg_r && rem_nz);
      end else if (ph_r == PH_CLAMP) begin
        res_nxt  = neg_r ? -$signed(mag) : $signed(mag);
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    ph_r    <= ph_nxt;
    ua_r    <= ua_nxt;
    ub_r    <= ub_nxt;
    neg_r   <= neg_nxt;
    sh24_r  <= sh24_nxt;
    lstep_r <= lstep_nxt;
    acc_r   <= acc_nxt;
    q_r     <= q_nxt;
    res_r   <= res_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

### rtl/core/linear_regression_gradient_descent_unit.sv
// Load and clear transfers are taken only while idle; a start transfer then runs training.
// One pass over m rows and nf features uses the shared multiplier for every product
// and a serial divide of the squared-residual sum by 2*m for the cost.
// Training makes one extra residual sweep first, then nf weights leave one per transfer.
// Reset is synchronous and active low; it idles the sequencer, clears the row and column
// counts and presets the config registers. Store contents are not cleared by reset.
`timescale 1ns / 1ps

module linear_regression_gradient_descent_unit #(
  parameter int MAX_SAMPLES  = lrgd_pkg::DEF_MAX_SAMPLES,
  parameter int MAX_FEATURES = lrgd_pkg::DEF_MAX_FEATURES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lrgd_pkg::lrgd_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lrgd_pkg::lrgd_out_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int NW     = (MAX_FEATURES < lrgd_pkg::FEAT_LIMIT) ? MAX_FEATURES
                                                                 : lrgd_pkg::FEAT_LIMIT;
  localparam int WI_W   = (NW > 1) ? $clog2(NW) : 1;
  localparam int SI_W   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int FDEPTH = MAX_SAMPLES * MAX_FEATURES;
  localparam int FA_W   = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;
  localparam logic [4:0]       NW_V    = 5'(NW);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

  localparam logic signed [64:0] R_HI  = 65'sd140737488355327;
  localparam logic signed [64:0] R_LO  = -R_HI - 65'sd1;
  localparam logic signed [64:0] G_HI  = 65'sd9223372036854775807;
  localparam logic signed [64:0] G_LO  = -G_HI;
  localparam logic signed [42:0] W_HI  = 43'sd2147483647;
  localparam logic signed [42:0] W_LO  = -W_HI - 43'sd1;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_R_ROW   = 5'd1;
  localparam logic [4:0] S_R_RD    = 5'd2;
  localparam logic [4:0] S_R_MUL   = 5'd3;
  localparam logic [4:0] S_R_WAIT  = 5'd4;
  localparam logic [4:0] S_R_RES   = 5'd5;
  localparam logic [4:0] S_R_SQ    = 5'd6;
  localparam logic [4:0] S_R_SQW   = 5'd7;
  localparam logic [4:0] S_DIV     = 5'd8;
  localparam logic [4:0] S_CHECK   = 5'd9;
  localparam logic [4:0] S_U_COL   = 5'd10;
  localparam logic [4:0] S_U_RD    = 5'd11;
  localparam logic [4:0] S_U_MUL   = 5'd12;
  localparam logic [4:0] S_U_WAIT  = 5'd13;
  localparam logic [4:0] S_U_STEP  = 5'd14;
  localparam logic [4:0] S_U_SWAIT = 5'd15;
  localparam logic [4:0] S_EMIT    = 5'd16;

  logic [4:0]  state_r, state_nxt;
  logic [4:0]  fc_r, fc_nxt;
  logic [23:0] lr_r, lr_nxt;
  logic [31:0] thr_r, thr_nxt;
  logic [15:0] cap_r, cap_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, j_r, j_nxt;
  logic [4:0]  col_r, col_nxt, i_r, i_nxt;
  logic signed [31:0] weights_r [NW];
  logic signed [31:0] weights_nxt [NW];
  logic signed [63:0] h_r, h_nxt, g_r, g_nxt;
  logic signed [47:0] r_r, r_nxt;
  logic [63:0] sum_r, sum_nxt, cost_r, cost_nxt, prev_r, prev_nxt, dq_r, dq_nxt;
  logic [15:0] passes_r, passes_nxt;
  logic        status_r, status_nxt, init_r, init_nxt;
  logic [CNT_W:0] rem_r, rem_nxt;
  logic [5:0]  dc_r, dc_nxt;

  logic signed [31:0] fmem [FDEPTH];
  logic signed [31:0] tmem [MAX_SAMPLES];
  logic signed [47:0] rmem [MAX_SAMPLES];
  logic signed [31:0] fdata_r, tdata_r;
  logic signed [47:0] rdata_r;

  logic            in_fire, cfg_we, f_we, t_we, r_we;
  logic [FA_W-1:0] f_waddr, f_raddr;
  logic [4:0]      nf;
  logic [15:0]     cap_eff;
  logic [WI_W-1:0] widx;

  lrgd_pkg::lrgd_mul_req_t mreq;
  logic signed [63:0] mop_a, mop_b, mres;
  logic               mdone;

  logic signed [64:0] rdiff, gsum;
  logic signed [47:0] res_sat;
  logic signed [63:0] g_sat;
  logic [64:0]        ssum;
  logic [63:0]        sum_sat, cdiff;
  logic signed [42:0] wdiff;
  logic signed [31:0] w_sat;
  logic [CNT_W+1:0]   rem_sh, dvs, rem_sub;
  logic               div_bit;
  logic [CNT_W:0]     div_rem;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign cfg_we   = psel && penable && pwrite;
  assign pready   = 1'b1;
  assign widx     = i_r[WI_W-1:0];
  assign nf       = (fc_r == 5'd0) ? 5'd1 : ((fc_r > NW_V) ? NW_V : fc_r);
  assign cap_eff  = (cap_r == 16'd0) ? 16'd1 : cap_r;

  assign f_we    = in_fire && (in_data.cmd == lrgd_pkg::CMD_FEATURE) && (cnt_r < CNT_MAX)
                   && (col_r < nf);
  assign t_we    = in_fire && (in_data.cmd == lrgd_pkg::CMD_TARGET) && (cnt_r < CNT_MAX);
  assign r_we    = (state_r == S_R_RES);
  assign f_waddr = FA_W'(int'(cnt_r) * MAX_FEATURES + int'(col_r));
  assign f_raddr = FA_W'(int'(j_r) * MAX_FEATURES + int'(i_r));

  always_ff @(posedge clk) begin
    if (f_we) begin
      fmem[f_waddr] <= in_data.value;
    end
    if (t_we) begin
      tmem[cnt_r[SI_W-1:0]] <= in_data.value;
    end
    if (r_we) begin
      rmem[j_r[SI_W-1:0]] <= res_sat;
    end
    fdata_r <= fmem[f_raddr];
    tdata_r <= tmem[j_r[SI_W-1:0]];
    rdata_r <= rmem[j_r[SI_W-1:0]];
  end

  always_comb begin
    mreq.start    = (state_r == S_R_MUL) || (state_r == S_R_SQ) ||
                    (state_r == S_U_MUL) || (state_r == S_U_STEP);
    mreq.shift24  = (state_r == S_U_STEP);
    mreq.lim_step = (state_r == S_U_STEP);
    priority if (state_r == S_R_SQ) begin
      mop_a = 64'(r_r);
      mop_b = 64'(r_r);
    end else if (state_r == S_U_MUL) begin
      mop_a = 64'(rdata_r);
      mop_b = 64'(fdata_r);
    end else if (state_r == S_U_STEP) begin
      mop_a = $signed({40'd0, lr_r});
      mop_b = g_r;
    end else begin
      mop_a = 64'(weights_r[widx]);
      mop_b = 64'(fdata_r);
    end
  end

  lrgd_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (mreq),
    .op_a   (mop_a),
    .op_b   (mop_b),
    .done   (mdone),
    .result (mres)
  );

  always_comb begin
    rdiff   = 65'(h_r) - 65'(tdata_r);
    res_sat = (rdiff > R_HI) ? 48'(R_HI) : ((rdiff < R_LO) ? 48'(R_LO) : 48'(rdiff));
    gsum    = 65'(g_r) + 65'(mres);
    g_sat   = (gsum > G_HI) ? 64'(G_HI) : ((gsum < G_LO) ? 64'(G_LO) : 64'(gsum));
    ssum    = {1'b0, sum_r} + {1'b0, mres};
    sum_sat = ssum[64] ? {64{1'b1}} : ssum[63:0];
    wdiff   = 43'(weights_r[widx]) - 43'(mres[42:0]);
    w_sat   = (wdiff > W_HI) ? 32'(W_HI) : ((wdiff < W_LO) ? 32'(W_LO) : 32'(wdiff));
    cdiff   = (cost_r > prev_r) ? (cost_r - prev_r) : (prev_r - cost_r);
    rem_sh  = {rem_r, dq_r[63]};
    dvs     = {1'b0, cnt_r, 1'b0};
    rem_sub = rem_sh - dvs;
    div_bit = (rem_sh >= dvs);
    div_rem = div_bit ? rem_sub[CNT_W:0] : rem_sh[CNT_W:0];
  end

  always_comb begin
    state_nxt   = state_r;
    fc_nxt      = fc_r;
    lr_nxt      = lr_r;
    thr_nxt     = thr_r;
    cap_nxt     = cap_r;
    cnt_nxt     = cnt_r;
    col_nxt     = col_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    h_nxt       = h_r;
    r_nxt       = r_r;
    g_nxt       = g_r;
    sum_nxt     = sum_r;
    cost_nxt    = cost_r;
    prev_nxt    = prev_r;
    passes_nxt  = passes_r;
    status_nxt  = status_r;
    init_nxt    = init_r;
    dq_nxt      = dq_r;
    rem_nxt     = rem_r;
    dc_nxt      = dc_r;
    weights_nxt = weights_r;

    if (cfg_we) begin
      unique case (paddr[3:2])
        lrgd_pkg::REG_FEATURE_COUNT:  fc_nxt  = pwdata[4:0];
        lrgd_pkg::REG_LEARN_RATE:     lr_nxt  = pwdata[23:0];
        lrgd_pkg::REG_STOP_THRESHOLD: thr_nxt = pwdata;
        lrgd_pkg::REG_ITERATION_CAP:  cap_nxt = pwdata[15:0];
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_data.cmd)
            lrgd_pkg::CMD_FEATURE: begin
              if (col_r != 5'd31) col_nxt = col_r + 5'd1;
            end
            lrgd_pkg::CMD_TARGET: begin
              if (cnt_r < CNT_MAX) cnt_nxt = cnt_r + CNT_W'(1);
              col_nxt = 5'd0;
            end
            lrgd_pkg::CMD_START: begin
              for (int k = 0; k < NW; k++) weights_nxt[k] = 32'sd0;
              prev_nxt   = lrgd_pkg::PRIOR_COST;
              passes_nxt = 16'd0;
              init_nxt   = 1'b1;
              j_nxt      = '0;
              sum_nxt    = 64'd0;
              state_nxt  = S_R_ROW;
            end
            lrgd_pkg::CMD_CLEAR: begin
              cnt_nxt = '0;
              col_nxt = 5'd0;
            end
          endcase
        end
      end
      S_R_ROW: begin
        if (j_r == cnt_r) begin
          if (cnt_r == '0) begin
            cost_nxt  = 64'd0;
            state_nxt = S_CHECK;
          end else begin
            dq_nxt    = sum_r;
            rem_nxt   = '0;
            dc_nxt    = 6'd0;
            state_nxt = S_DIV;
          end
        end else begin
          h_nxt     = 64'sd0;
          i_nxt     = 5'd0;
          state_nxt = S_R_RD;
        end
      end
      S_R_RD:  state_nxt = S_R_MUL;
      S_R_MUL: state_nxt = S_R_WAIT;
      S_R_WAIT: begin
        if (mdone) begin
          h_nxt = h_r + mres;
          if (i_r + 5'd1 == nf) begin
            state_nxt = S_R_RES;
          end else begin
            i_nxt     = i_r + 5'd1;
            state_nxt = S_R_RD;
          end
        end
      end
      S_R_RES: begin
        r_nxt     = res_sat;
        state_nxt = S_R_SQ;
      end
      S_R_SQ: state_nxt = S_R_SQW;
      S_R_SQW: begin
        if (mdone) begin
          sum_nxt   = sum_sat;
          j_nxt     = j_r + CNT_W'(1);
          state_nxt = S_R_ROW;
        end
      end
      S_DIV: begin
        dq_nxt  = {dq_r[62:0], div_bit};
        rem_nxt = div_rem;
        dc_nxt  = dc_r + 6'd1;
        if (dc_r == 6'd63) begin
          cost_nxt  = {dq_r[62:0], div_bit};
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        i_nxt = 5'd0;
        priority if (init_r) begin
          init_nxt  = 1'b0;
          state_nxt = S_U_COL;
        end else if (cdiff <= {32'd0, thr_r}) begin
          status_nxt = 1'b0;
          prev_nxt   = cost_r;
          state_nxt  = S_EMIT;
        end else if (passes_r >= cap_eff) begin
          status_nxt = 1'b1;
          prev_nxt   = cost_r;
          state_nxt  = S_EMIT;
        end else begin
          prev_nxt  = cost_r;
          state_nxt = S_U_COL;
        end
      end
      S_U_COL: begin
        g_nxt     = 64'sd0;
        j_nxt     = '0;
        state_nxt = (cnt_r == '0) ? S_U_STEP : S_U_RD;
      end
      S_U_RD:  state_nxt = S_U_MUL;
      S_U_MUL: state_nxt = S_U_WAIT;
      S_U_WAIT: begin
        if (mdone) begin
          g_nxt = g_sat;
          if (j_r + CNT_W'(1) == cnt_r) begin
            state_nxt = S_U_STEP;
          end else begin
            j_nxt     = j_r + CNT_W'(1);
            state_nxt = S_U_RD;
          end
        end
      end
      S_U_STEP: state_nxt = S_U_SWAIT;
      S_U_SWAIT: begin
        if (mdone) begin
          weights_nxt[widx] = w_sat;
          if (i_r + 5'd1 == nf) begin
            passes_nxt = passes_r + 16'd1;
            j_nxt      = '0;
            sum_nxt    = 64'd0;
            state_nxt  = S_R_ROW;
          end else begin
            i_nxt     = i_r + 5'd1;
            state_nxt = S_U_COL;
          end
        end
      end
      S_EMIT: begin
        if (out_ready) begin
          if (i_r + 5'd1 == nf) begin
            state_nxt = S_IDLE;
          end else begin
            i_nxt = i_r + 5'd1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fc_r    <= lrgd_pkg::RST_FEATURE_COUNT;
      lr_r    <= lrgd_pkg::RST_LEARN_RATE;
      thr_r   <= lrgd_pkg::RST_STOP_THRESHOLD;
      cap_r   <= lrgd_pkg::RST_ITERATION_CAP;
      cnt_r   <= '0;
      col_r   <= 5'd0;
    end else begin
      state_r <= state_nxt;
      fc_r    <= fc_nxt;
      lr_r    <= lr_nxt;
      thr_r   <= thr_nxt;
      cap_r   <= cap_nxt;
      cnt_r   <= cnt_nxt;
      col_r   <= col_nxt;
    end
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    h_r       <= h_nxt;
    r_r       <= r_nxt;
    g_r       <= g_nxt;
    sum_r     <= sum_nxt;
    cost_r    <= cost_nxt;
    prev_r    <= prev_nxt;
    passes_r  <= passes_nxt;
    status_r  <= status_nxt;
    init_r    <= init_nxt;
    dq_r      <= dq_nxt;
    rem_r     <= rem_nxt;
    dc_r      <= dc_nxt;
    weights_r <= weights_nxt;
  end

  always_comb begin
    unique case (paddr[3:2])
      lrgd_pkg::REG_FEATURE_COUNT:  prdata = {27'd0, fc_r};
      lrgd_pkg::REG_LEARN_RATE:     prdata = {8'd0, lr_r};
      lrgd_pkg::REG_STOP_THRESHOLD: prdata = thr_r;
      lrgd_pkg::REG_ITERATION_CAP:  prdata = {16'd0, cap_r};
    endcase
  end

  assign out_valid             = (state_r == S_EMIT);
  assign out_data.weight       = weights_r[widx];
  assign out_data.weight_index = i_r[3:0];
  assign out_data.last         = (i_r + 5'd1 == nf);
  assign out_data.status       = status_r;
  assign out_data.passes       = passes_r;

endmodule

### rtl/core/lrgd_checker.sv
`timescale 1ns / 1ps

module lrgd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input lrgd_pkg::lrgd_in_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input lrgd_pkg::lrgd_out_t out_data
);

  // Loading and emitting never overlap.
  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while results are pending");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A start transfer closes the input until the run has been delivered.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.cmd == lrgd_pkg::CMD_START |=> !in_ready)
    else $error("input ready straight after a start");

  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last |=> out_valid)
    else $error("result burst ended before its last weight");

  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.last |=> in_ready && !out_valid)
    else $error("input not reopened after the last weight");

endmodule

bind linear_regression_gradient_descent_unit lrgd_checker u_lrgd_checker (.*);

### tb/tb_top.sv
`timescale 1ns / 1ps

class lrgd_scoreboard;
  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] RES_MAX = 64'sd140737488355327;
  localparam logic signed [63:0] RES_MIN = -64'sd140737488355328;

  int unsigned fcount_reg = 1;
  int unsigned rate_reg = 65536;
  int unsigned thresh_reg = 65;
  int unsigned cap_reg = 1000;

  logic signed [31:0] feat[256][16];
  bit                 written[256][16];
  logic signed [31:0] tgt[256];
  logic signed [31:0] wt[16];
  logic signed [63:0] resid[256];
  int unsigned        rows = 0;
  int unsigned        col = 0;

  lrgd_pkg::lrgd_out_t weights_due[$];
  int errors = 0;

  function void set_reg(logic [1:0] idx, logic [31:0] v);
    case (idx)
      lrgd_pkg::REG_FEATURE_COUNT:  fcount_reg = v[4:0];
      lrgd_pkg::REG_LEARN_RATE:     rate_reg = v[23:0];
      lrgd_pkg::REG_STOP_THRESHOLD: thresh_reg = v;
      default:                      cap_reg = v[15:0];
    endcase
  endfunction

  function int unsigned eff_nf();
    if (fcount_reg < 1) return 1;
    if (fcount_reg > 16) return 16;
    return fcount_reg;
  endfunction

  function bit slot_full(int unsigned nf);
    if (rows >= 256) return 1;
    for (int i = 0; i < nf; i++) if (!written[rows][i]) return 0;
    return 1;
  endfunction

  function logic signed [63:0] mul_floor(logic signed [63:0] a, logic signed [63:0] b,
                                          int sh, logic signed [63:0] lim);
    logic signed [127:0] ea, eb, p;
    ea = a;
    eb = b;
    p = (ea * eb) >>> sh;
    if (p > lim) return lim;
    if (p < -lim) return -lim;
    return p[63:0];
  endfunction

  function logic [63:0] sweep(int unsigned nf);
    logic [64:0]        sum;
    logic signed [63:0] h, r, t64, sq;
    sum = 0;
    for (int j = 0; j < rows; j++) begin
      h = 0;
      for (int i = 0; i < nf; i++) h += mul_floor(wt[i], feat[j][i], 16, S64_MAX);
      t64 = tgt[j];
      r = h - t64;
      if (r > RES_MAX) r = RES_MAX;
      if (r < RES_MIN) r = RES_MIN;
      resid[j] = r;
      sq = mul_floor(r, r, 16, S64_MAX);
      sum = sum + {1'b0, sq};
      if (sum[64]) sum = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
    end
    if (rows == 0) return 0;
    return sum[63:0] / (64'(rows) * 2);
  endfunction

  function void update(int unsigned nf);
    logic signed [64:0] gs;
    logic signed [63:0] g, step, ww;
    for (int i = 0; i < nf; i++) begin
      g = 0;
      for (int j = 0; j < rows; j++) begin
        gs = 65'(g) + 65'(mul_floor(resid[j], feat[j][i], 16, S64_MAX));
        if (gs > 65'(S64_MAX)) gs = 65'(S64_MAX);
        if (gs < -65'(S64_MAX)) gs = -65'(S64_MAX);
        g = gs[63:0];
      end
      step = mul_floor($signed({40'd0, rate_reg[23:0]}), g, 24,
                       $signed(lrgd_pkg::STEP_LIM));
      ww = 64'(wt[i]) - step;
      if (ww > 64'sd2147483647) ww = 64'sd2147483647;
      if (ww < -64'sd2147483648) ww = -64'sd2147483648;
      wt[i] = ww[31:0];
    end
  endfunction

  function void note(lrgd_pkg::lrgd_in_t it);
    int unsigned nf, cap, passes;
    logic [63:0] prev, cost, diff;
    bit          capped;
    lrgd_pkg::lrgd_out_t o;
    nf = eff_nf();
    case (it.cmd)
      lrgd_pkg::CMD_FEATURE: begin
        if (rows < 256 && col < nf) begin
          feat[rows][col] = it.value;
          written[rows][col] = 1;
        end
        if (col < 31) col++;
      end
      lrgd_pkg::CMD_TARGET: begin
        if (rows < 256) begin
          tgt[rows] = it.value;
          rows++;
        end
        col = 0;
      end
      lrgd_pkg::CMD_CLEAR: begin
        rows = 0;
        col = 0;
      end
      default: begin
        cap = (cap_reg == 0) ? 1 : cap_reg;
        passes = 0;
        capped = 0;
        for (int i = 0; i < 16; i++) wt[i] = 0;
        prev = lrgd_pkg::PRIOR_COST;
        void'(sweep(nf));
        forever begin
          update(nf);
          passes++;
          cost = sweep(nf);
          diff = (cost > prev) ? cost - prev : prev - cost;
          if (diff <= 64'(thresh_reg)) break;
          if (passes >= cap) begin
            capped = 1;
            break;
          end
          prev = cost;
        end
        for (int i = 0; i < nf; i++) begin
          o.weight = wt[i];
          o.weight_index = i[3:0];
          o.last = (i + 1 == nf);
          o.status = capped;
          o.passes = passes[15:0];
          weights_due = {weights_due, o};
        end
      end
    endcase
  endfunction

  function void check(lrgd_pkg::lrgd_out_t got);
    lrgd_pkg::lrgd_out_t want;
    if (weights_due.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected weight transfer: %p", got);
      return;
    end
    want = weights_due.pop_front();
    if (got.weight !== want.weight || got.weight_index !== want.weight_index ||
        got.last !== want.last || got.status !== want.status ||
        got.passes !== want.passes) begin
      errors++;
      if (errors <= 10)
        $display({"weight mismatch: expected w=%0d idx=%0d last=%0d st=%0d n=%0d, ",
                  "got w=%0d idx=%0d last=%0d st=%0d n=%0d"},
                 want.weight, want.weight_index, want.last, want.status, want.passes,
                 got.weight, got.weight_index, got.last, got.status, got.passes);
    end
  endfunction
endclass

module tb_top;

  localparam int LIMIT = 3000000;
  localparam int MODE_NONE = 0;
  localparam int MODE_SEND = 1;
  localparam int MODE_RECV = 2;
  localparam int MODE_BOTH = 3;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  lrgd_pkg::lrgd_in_t  in_data;
  logic                out_valid;
  logic                out_ready = 1'b0;
  lrgd_pkg::lrgd_out_t out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [3:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  lrgd_scoreboard sb = new();
  int  mode = MODE_NONE;
  int  sent = 0;
  int  cycles = 0;
  bit  hold_req = 0;
  int  hold_left = 0;

  linear_regression_gradient_descent_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check(out_data);
    if (hold_req) begin
      hold_left = 3000;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 0;
    end else if (mode == MODE_RECV) begin
      out_ready <= ($urandom_range(99) >= 81);
    end else if (mode == MODE_BOTH) begin
      out_ready <= ($urandom_range(99) >= 7);
    end else begin
      out_ready <= 1;
    end
  end

  function automatic logic [31:0] rand_val();
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1: return $urandom();
      default: return $urandom_range(0, 32'h6_0000) - 32'h3_0000;
    endcase
  endfunction

  task automatic send(logic [1:0] cmd, logic [31:0] v);
    int p;
    lrgd_pkg::lrgd_in_t it;
    it.cmd = cmd;
    it.value = v;
    in_valid <= 1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.note(it);
    sent++;
    p = (mode == MODE_SEND) ? 81 : (mode == MODE_BOTH) ? 7 : 0;
    if ($urandom_range(99) < p) begin
      in_valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < p);
    end
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] v);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    sb.set_reg(idx, v);
  endtask

  task automatic drain();
    in_valid <= 0;
    do @(posedge clk); while (sb.weights_due.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic new_phase(int fc, int lr, logic [31:0] thr, int cap, int m);
    drain();
    mode = m;
    cfg_write(lrgd_pkg::REG_FEATURE_COUNT, fc);
    cfg_write(lrgd_pkg::REG_LEARN_RATE, lr);
    cfg_write(lrgd_pkg::REG_STOP_THRESHOLD, thr);
    cfg_write(lrgd_pkg::REG_ITERATION_CAP, cap);
    send(lrgd_pkg::CMD_CLEAR, rand_val());
  endtask

  task automatic send_row();
    int nf, need, len;
    nf = sb.eff_nf();
    need = sb.slot_full(nf) ? 0 : (nf > sb.col ? nf - sb.col : 0);
    len = need + $urandom_range(0, (need == 0) ? nf + 1 : 2);
    repeat (len) send(lrgd_pkg::CMD_FEATURE, rand_val());
    send(lrgd_pkg::CMD_TARGET, rand_val());
  endtask

  task automatic rand_items(int n);
    int stop_at, r;
    stop_at = sent + n;
    while (sent < stop_at) begin
      r = $urandom_range(99);
      if (sb.rows >= 6) send(lrgd_pkg::CMD_CLEAR, rand_val());
      else if (r < 70) send_row();
      else if (r < 82) send(lrgd_pkg::CMD_START, rand_val());
      else if (r < 87) send(lrgd_pkg::CMD_CLEAR, rand_val());
      else if (sb.rows < 256 && sb.col < sb.eff_nf() && !sb.written[sb.rows][sb.col])
        send_row();
      else send(lrgd_pkg::CMD_FEATURE, rand_val());
    end
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    new_phase(3, 24'h10_0000, 0, 4, MODE_NONE);
    send(lrgd_pkg::CMD_START, 32'hFFFF_FFFF);
    send(lrgd_pkg::CMD_FEATURE, 32'h7FFF_FFFF);
    send(lrgd_pkg::CMD_FEATURE, 32'h8000_0000);
    send(lrgd_pkg::CMD_FEATURE, 32'h0);
    send(lrgd_pkg::CMD_FEATURE, 32'h1_0000);
    send(lrgd_pkg::CMD_TARGET, 32'hFFFF_FFFF);
    send(lrgd_pkg::CMD_FEATURE, 32'h1_0000);
    send(lrgd_pkg::CMD_FEATURE, 32'h2_0000);
    send(lrgd_pkg::CMD_FEATURE, 32'hFFFF_0000);
    send(lrgd_pkg::CMD_TARGET, 32'h3_0000);
    send(lrgd_pkg::CMD_FEATURE, 32'h8000);
    send(lrgd_pkg::CMD_FEATURE, 32'h1_8000);
    send(lrgd_pkg::CMD_FEATURE, 32'h4000);
    send(lrgd_pkg::CMD_TARGET, 32'h7FFF_FFFF);
    send(lrgd_pkg::CMD_START, 32'h0);
    send(lrgd_pkg::CMD_CLEAR, 32'h0);
    send(lrgd_pkg::CMD_FEATURE, 32'h1_0000);
    send(lrgd_pkg::CMD_TARGET, 32'h2_0000);
    send(lrgd_pkg::CMD_FEATURE, 32'h5000);
    send(lrgd_pkg::CMD_FEATURE, 32'h6000);
    send(lrgd_pkg::CMD_START, 32'h0);

    new_phase(2, 24'h20_0000, 32'h1_0000, 8, MODE_SEND);
    rand_items(30);
    new_phase(4, 24'hFF_FFFF, 0, 5, MODE_RECV);
    rand_items(30);
    new_phase(0, 24'h08_0000, 32'h400, 0, MODE_BOTH);
    rand_items(25);

    new_phase(31, 24'h00_0001, 32'hFFFF_FFFF, 3, MODE_NONE);
    hold_req = 1;
    repeat (34) send(lrgd_pkg::CMD_FEATURE, rand_val());
    send(lrgd_pkg::CMD_TARGET, rand_val());
    send_row();
    send(lrgd_pkg::CMD_START, 32'h0);
    send_row();
    send(lrgd_pkg::CMD_START, 32'h0);
    rand_items(10);

    new_phase(1, 0, 32'hFFFF_FFFF, 65535, MODE_SEND);
    rand_items(15);

    new_phase(1, 24'h00_0100, 0, 3, MODE_NONE);
    repeat (8) begin
      send(lrgd_pkg::CMD_FEATURE, rand_val());
      send(lrgd_pkg::CMD_TARGET, rand_val());
    end
    send(lrgd_pkg::CMD_FEATURE, rand_val());
    send(lrgd_pkg::CMD_START, 32'h0);

    new_phase(5, $urandom_range(0, 24'hFF_FFFF), $urandom_range(0, 32'h10_0000), 6,
              MODE_RECV);
    rand_items(25);

    drain();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.weights_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
